FILE: src/dss_pkg.sv
package dss_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned LIMIT_W = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned NUM_SLOTS  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd1;

  localparam logic [MODE_W-1:0]  MODE_RST  = 2'd0;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 4'd4;

  localparam int unsigned MODE_RECENT_BIT = 0;
  localparam int unsigned MODE_DOUBLE_BIT = 1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] kept_value;
    logic                      end_of_run;
    logic [COUNT_W-1:0]        kept_count;
  } out_item_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0]            valid;
    out_item_t [NUM_SLOTS-1:0]       item;
  } push_t;

endpackage

FILE: src/dss_fifo.sv
module dss_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_en_i,
  input  dss_pkg::push_t    push_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dss_pkg::out_item_t out_item_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = 2;

  dss_pkg::out_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic            pop;
  logic [PtrW-1:0] off [dss_pkg::NUM_SLOTS];
  logic [PtrW:0]   npush;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];
  // at least three free entries after this cycle's pop
  assign room_o      = ((count_q - {{PtrW{1'b0}}, pop}) <= (PtrW+1)'(1));

  always_comb begin
    off[0] = '0;
    off[1] = PtrW'(push_i.valid[0]);
    off[2] = PtrW'(push_i.valid[0]) + PtrW'(push_i.valid[1]);
    npush  = push_en_i ? ((PtrW+1)'(push_i.valid[0]) + (PtrW+1)'(push_i.valid[1])
                          + (PtrW+1)'(push_i.valid[2])) : '0;
    wr_ptr_d = wr_ptr_q + npush[PtrW-1:0];
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    count_d  = count_q + npush - {{PtrW{1'b0}}, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < dss_pkg::NUM_SLOTS; k++) begin
      if (push_en_i && push_i.valid[k]) begin
        mem_q[wr_ptr_q + off[k]] <= push_i.item[k];
      end
    end
  end

endmodule

FILE: src/dss_core.sv
module dss_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dss_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dss_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  dss_pkg::in_item_t                 in_item_i,
  input  logic                              room_i,
  output logic                              push_en_o,
  output dss_pkg::push_t                    push_o
);

  logic [dss_pkg::MODE_W-1:0]  mode_q;
  logic [dss_pkg::LIMIT_W-1:0] limit_q;

  logic                        in_valid_q;
  dss_pkg::in_item_t           item_q;
  logic                        fire;

  logic                                in_seq_q, in_seq_d;
  logic                                pend_valid_q, pend_valid_d;
  logic signed [dss_pkg::VALUE_W-1:0]  pend_q, pend_d;
  logic signed [dss_pkg::VALUE_W-1:0]  tail_q, tail_d;
  logic [dss_pkg::LIMIT_W-1:0]         drop_q, drop_d;
  logic [dss_pkg::COUNT_W-1:0]         kept_q, kept_d;

  logic recent, dbl, ok_next, keep_a, keep_b;
  logic signed [dss_pkg::VALUE_W-1:0] tail_a;

  assign fire       = in_valid_q && room_i;
  assign in_ready_o = !in_valid_q || fire;
  assign push_en_o  = fire;
  assign recent     = mode_q[dss_pkg::MODE_RECENT_BIT];
  assign dbl        = mode_q[dss_pkg::MODE_DOUBLE_BIT];

  always_comb begin
    in_seq_d     = in_seq_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    tail_d       = tail_q;
    drop_d       = drop_q;
    kept_d       = kept_q;
    push_o       = '0;
    ok_next      = 1'b0;
    keep_a       = 1'b0;
    keep_b       = 1'b0;
    tail_a       = tail_q;

    if (!in_seq_q) begin
      in_seq_d     = 1'b1;
      tail_d       = item_q.value;
      kept_d       = dss_pkg::COUNT_W'(1);
      drop_d       = '0;
      pend_valid_d = 1'b0;
      pend_d       = '0;
    end else begin
      // held item, decided against the new one
      if (pend_valid_q) begin
        pend_valid_d = 1'b0;
        ok_next      = (pend_q <= item_q.value);
        keep_a       = (pend_q >= tail_q) && ok_next;
        if (keep_a) begin
          push_o.valid[0]           = 1'b1;
          push_o.item[0].kept_value = tail_q;
          tail_d                    = pend_q;
          if (kept_d != '1) kept_d = kept_d + dss_pkg::COUNT_W'(1);
        end else if (recent) begin
          drop_d = drop_d + dss_pkg::LIMIT_W'(1);
          if (drop_d >= limit_q) begin
            drop_d = '0;
            tail_d = pend_q;
          end
        end
      end
      tail_a = tail_d;
      if (dbl && !item_q.last) begin
        pend_d       = item_q.value;
        pend_valid_d = 1'b1;
      end else begin
        keep_b = (item_q.value >= tail_a);
        if (keep_b) begin
          push_o.valid[1]           = 1'b1;
          push_o.item[1].kept_value = tail_a;
          tail_d                    = item_q.value;
          if (kept_d != '1) kept_d = kept_d + dss_pkg::COUNT_W'(1);
        end else if (recent) begin
          drop_d = drop_d + dss_pkg::LIMIT_W'(1);
          if (drop_d >= limit_q) begin
            drop_d = '0;
            tail_d = item_q.value;
          end
        end
      end
    end

    if (item_q.last) begin
      push_o.valid[2]           = 1'b1;
      push_o.item[2].kept_value = tail_d;
      push_o.item[2].end_of_run = 1'b1;
      push_o.item[2].kept_count = kept_d;
      in_seq_d     = 1'b0;
      pend_valid_d = 1'b0;
      pend_d       = '0;
      tail_d       = '0;
      drop_d       = '0;
      kept_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= dss_pkg::MODE_RST;
      limit_q      <= dss_pkg::LIMIT_RST;
      in_valid_q   <= 1'b0;
      in_seq_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_q       <= '0;
      tail_q       <= '0;
      drop_q       <= '0;
      kept_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          dss_pkg::CFG_MODE:  mode_q  <= cfg_data_i[dss_pkg::MODE_W-1:0];
          dss_pkg::CFG_LIMIT: limit_q <= cfg_data_i[dss_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (fire) begin
        in_seq_q     <= in_seq_d;
        pend_valid_q <= pend_valid_d;
        pend_q       <= pend_d;
        tail_q       <= tail_d;
        drop_q       <= drop_d;
        kept_q       <= kept_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) item_q <= in_item_i;
  end

endmodule

FILE: src/drop_sort_stream_filter.sv
// channel | direction | handshake              | payload
// --------+-----------+------------------------+--------------------------------
// in      | input     | in_valid_i/in_ready_o   | in_item_i (value, last)
// out     | output    | out_valid_o/out_ready_i | out_item_o (kept_value, end_of_run,
//         |           |                        |   kept_count)
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle: an input register feeds the compare/update logic, which
// pushes zero to three results into a 4-entry result queue in the same cycle.
// An item moves on only when the queue has three free entries; the final item
// of a sequence yields up to three results, so output drain sets the rate then.
// Reset (async, active low) clears the sequence state and queue; mode = 0,
// drop_limit = 4. Configuration writes are always accepted: cfg_ready_o is tied high.
module drop_sort_stream_filter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dss_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  dss_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output dss_pkg::out_item_t             out_item_o
);

  logic           room;
  logic           push_en;
  dss_pkg::push_t push;

  assign cfg_ready_o = 1'b1;

  dss_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .room_i      (room),
    .push_en_o   (push_en),
    .push_o      (push)
  );

  dss_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_en_i   (push_en),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
